// ===== sv/hsl_pkg.sv =====
package hsl_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int IN_BITS      = 16;
  localparam int FRAC_BITS    = 24;
  // Q0.24 levels reach ONE exactly, hence one extra bit
  localparam int Q_BITS       = FRAC_BITS + 1;

  // three top-level stages plus four per-channel ramp stages
  localparam int RAMP_STAGES  = 4;
  localparam int NUM_STAGES   = 3 + RAMP_STAGES;

  localparam logic [Q_BITS-1:0] Q_ONE        = Q_BITS'(1) << FRAC_BITS;
  localparam logic [Q_BITS-1:0] Q_HALF       = Q_BITS'(1) << (FRAC_BITS - 1);
  localparam logic [Q_BITS-1:0] Q_THIRD      = Q_BITS'(5592405);
  localparam logic [Q_BITS-1:0] Q_TWO_THIRDS = Q_BITS'(11184810);

  localparam logic [CHANNEL_BITS-1:0] CH_MAX = {CHANNEL_BITS{1'b1}};

  typedef logic [1:0] ramp_sel_t;
  localparam ramp_sel_t RAMP_UP   = 2'd0;
  localparam ramp_sel_t RAMP_HI   = 2'd1;
  localparam ramp_sel_t RAMP_DOWN = 2'd2;
  localparam ramp_sel_t RAMP_LO   = 2'd3;

  typedef struct packed {
    logic [IN_BITS-1:0] hue;
    logic [IN_BITS-1:0] saturation;
    logic [IN_BITS-1:0] lightness;
  } hsl_in_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } rgb_out_t;

endpackage

// ===== sv/hsl_ramp.sv =====
module hsl_ramp (
  input  logic                                clk,
  input  logic [hsl_pkg::RAMP_STAGES-1:0]     en,
  input  logic [hsl_pkg::Q_BITS-1:0]          lo_i,
  input  logic [hsl_pkg::Q_BITS-1:0]          hi_i,
  input  logic [hsl_pkg::Q_BITS-1:0]          d_i,
  input  logic [hsl_pkg::Q_BITS-1:0]          pos_i,
  output logic [hsl_pkg::CHANNEL_BITS-1:0]    ch_o
);
  import hsl_pkg::*;

  // stage A: pick the ramp segment and its multiplier operand
  logic [Q_BITS+2:0]    six_v;
  logic [Q_BITS:0]      two_v;
  logic [Q_BITS+1:0]    three_v;
  logic [Q_BITS-1:0]    t_w;
  logic [Q_BITS+2:0]    six_t;
  ramp_sel_t            sel_nxt;
  logic [FRAC_BITS-1:0] m_nxt;

  ramp_sel_t            sel3_r, sel4_r;
  logic [FRAC_BITS-1:0] m3_r;
  logic [Q_BITS-1:0]    lo3_r, hi3_r, d3_r;
  logic [Q_BITS-1:0]    lo4_r, hi4_r, f4_r;
  logic [Q_BITS-1:0]    level5_r;
  logic [CHANNEL_BITS-1:0] ch6_r;

  logic [Q_BITS+FRAC_BITS-1:0]    dm_prod;
  logic [Q_BITS:0]                level_sum;
  logic [Q_BITS-1:0]              level_nxt;
  logic [Q_BITS+CHANNEL_BITS-1:0] sc_prod;
  logic [CHANNEL_BITS:0]          sc_w;

  always_comb begin
    six_v   = {1'b0, pos_i, 2'b00} + {2'b00, pos_i, 1'b0};
    two_v   = {pos_i, 1'b0};
    three_v = {1'b0, pos_i, 1'b0} + {2'b00, pos_i};
    t_w     = (pos_i <= Q_TWO_THIRDS) ? (Q_TWO_THIRDS - pos_i) : '0;
    six_t   = {1'b0, t_w, 2'b00} + {2'b00, t_w, 1'b0};
    if (six_v < {3'b000, Q_ONE}) begin
      sel_nxt = RAMP_UP;
      m_nxt   = six_v[FRAC_BITS-1:0];
    end else if (two_v < {1'b0, Q_ONE}) begin
      sel_nxt = RAMP_HI;
      m_nxt   = '0;
    end else if (three_v < {1'b0, Q_ONE, 1'b0}) begin
      sel_nxt = RAMP_DOWN;
      // falling segment keeps 6t below ONE
      m_nxt   = six_t[FRAC_BITS-1:0];
    end else begin
      sel_nxt = RAMP_LO;
      m_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sel3_r <= sel_nxt;
      m3_r   <= m_nxt;
      lo3_r  <= lo_i;
      hi3_r  <= hi_i;
      d3_r   <= d_i;
    end
  end

  // stage B: distance times ramp position
  assign dm_prod = d3_r * m3_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sel4_r <= sel3_r;
      lo4_r  <= lo3_r;
      hi4_r  <= hi3_r;
      f4_r   <= dm_prod[FRAC_BITS+Q_BITS-1:FRAC_BITS];
    end
  end

  // stage C: channel level; lo + f never exceeds hi
  assign level_sum = {1'b0, lo4_r} + {1'b0, f4_r};

  always_comb begin
    case (sel4_r) inside
      RAMP_UP, RAMP_DOWN: level_nxt = level_sum[Q_BITS-1:0];
      RAMP_HI:            level_nxt = hi4_r;
      default:            level_nxt = lo4_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      level5_r <= level_nxt;
    end
  end

  // stage D: scale to channel range, truncate, saturate
  assign sc_prod = level5_r * CH_MAX;
  assign sc_w    = sc_prod[Q_BITS+CHANNEL_BITS-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      ch6_r <= (sc_w > {1'b0, CH_MAX}) ? CH_MAX : sc_w[CHANNEL_BITS-1:0];
    end
  end

  assign ch_o = ch6_r;

endmodule

// ===== sv/hsl_to_rgb_converter_core.sv =====
// HSL to RGB colour converter.
// Input channel: in_valid / in_stall with in_data carrying hue, saturation and
// lightness as 16-bit fractions of 65535. Result channel: out_valid /
// out_stall with out_data carrying red, green and blue at CHANNEL_BITS each.
// A transaction happens on a rising edge with valid high and stall low.
// Each input transaction passes through seven register stages to out_data;
// throughput is one transaction per cycle while out_stall is low. The
// stages are: fraction conversion,
// lightness-saturation product, level forming, then per channel segment
// select, distance multiply, level add and scale by the channel maximum.
// Each stage carries its own valid bit; a stage loads whenever it is empty
// or the stage after it moves, so bubbles close up and the input keeps being
// taken while a finished result waits. in_stall rises only when every stage
// holds an item and the receiver stalls. Stalled results stay on out_data.
// Reset (rst_n low, synchronous) empties the pipeline; no clearing pass.
module hsl_to_rgb_converter_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hsl_pkg::hsl_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output hsl_pkg::rgb_out_t out_data
);
  import hsl_pkg::*;

  // floor(x * 2^24 / 65535) as 256x + floor(256x / 65535)
  function automatic logic [Q_BITS-1:0] to_q24(input logic [IN_BITS-1:0] x);
    logic [IN_BITS:0]  rem;
    logic [Q_BITS-1:0] q;
    rem = {1'b0, x[7:0], 8'd0} + {9'd0, x[15:8]};
    q   = {1'b0, x, 8'd0} + {17'd0, x[15:8]} + {24'd0, (rem >= 17'd65535)};
    return q;
  endfunction

  logic [NUM_STAGES-1:0] valid_r, valid_nxt;
  logic [NUM_STAGES-1:0] grey_r, grey_nxt;
  logic [NUM_STAGES-1:0] adv;

  always_comb begin
    adv[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !valid_r[k] || adv[k+1];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    grey_nxt  = grey_r;
    if (adv[0]) begin
      valid_nxt[0] = in_valid;
      grey_nxt[0]  = (in_data.saturation == '0);
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (adv[k]) begin
        valid_nxt[k] = valid_r[k-1];
        grey_nxt[k]  = grey_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grey_r <= grey_nxt;
  end

  assign in_stall  = !adv[0];
  assign out_valid = valid_r[NUM_STAGES-1];

  // stage 0: fractions to Q0.24
  logic [Q_BITS-1:0] h0_r, s0_r, l0_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      h0_r <= to_q24(in_data.hue);
      s0_r <= to_q24(in_data.saturation);
      l0_r <= to_q24(in_data.lightness);
    end
  end

  // stage 1: L*S product and wrapped hue positions
  logic [2*Q_BITS-1:0] ls_prod;
  logic [Q_BITS:0]     pr_sum;
  logic [Q_BITS-1:0]   pr_nxt, pb_nxt;
  logic [Q_BITS-1:0]   p1_r, l1_r, s1_r, pr1_r, pg1_r, pb1_r;

  assign ls_prod = l0_r * s0_r;
  assign pr_sum  = {1'b0, h0_r} + {1'b0, Q_THIRD};
  assign pr_nxt  = (pr_sum > {1'b0, Q_ONE}) ? Q_BITS'(pr_sum - {1'b0, Q_ONE})
                                            : pr_sum[Q_BITS-1:0];
  assign pb_nxt  = (h0_r < Q_THIRD) ? (h0_r + Q_ONE - Q_THIRD) : (h0_r - Q_THIRD);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      p1_r  <= ls_prod[FRAC_BITS+Q_BITS-1:FRAC_BITS];
      l1_r  <= l0_r;
      s1_r  <= s0_r;
      pr1_r <= pr_nxt;
      pg1_r <= h0_r;
      pb1_r <= pb_nxt;
    end
  end

  // stage 2: hi, lo and their distance
  logic [Q_BITS+1:0] hi_w, two_l, lo_w, d_w;
  logic [Q_BITS-1:0] hi2_r, lo2_r, d2_r, pr2_r, pg2_r, pb2_r;

  always_comb begin
    if (l1_r < Q_HALF) begin
      hi_w = {2'b00, l1_r} + {2'b00, p1_r};
    end else begin
      hi_w = {2'b00, l1_r} + {2'b00, s1_r} - {2'b00, p1_r};
    end
    two_l = {1'b0, l1_r, 1'b0};
    lo_w  = (two_l >= hi_w) ? (two_l - hi_w) : '0;
    d_w   = (hi_w >= lo_w) ? (hi_w - lo_w) : '0;
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      if (grey_r[1]) begin
        hi2_r <= l1_r;
        lo2_r <= l1_r;
        d2_r  <= '0;
      end else begin
        hi2_r <= hi_w[Q_BITS-1:0];
        lo2_r <= lo_w[Q_BITS-1:0];
        d2_r  <= d_w[Q_BITS-1:0];
      end
      pr2_r <= pr1_r;
      pg2_r <= pg1_r;
      pb2_r <= pb1_r;
    end
  end

  // stages 3..6: one ramp per channel
  logic [CHANNEL_BITS-1:0] red_ch, green_ch, blue_ch;

  hsl_ramp u_ramp_red (
    .clk   (clk),
    .en    (adv[NUM_STAGES-1:3]),
    .lo_i  (lo2_r),
    .hi_i  (hi2_r),
    .d_i   (d2_r),
    .pos_i (pr2_r),
    .ch_o  (red_ch)
  );

  hsl_ramp u_ramp_green (
    .clk   (clk),
    .en    (adv[NUM_STAGES-1:3]),
    .lo_i  (lo2_r),
    .hi_i  (hi2_r),
    .d_i   (d2_r),
    .pos_i (pg2_r),
    .ch_o  (green_ch)
  );

  hsl_ramp u_ramp_blue (
    .clk   (clk),
    .en    (adv[NUM_STAGES-1:3]),
    .lo_i  (lo2_r),
    .hi_i  (hi2_r),
    .d_i   (d2_r),
    .pos_i (pb2_r),
    .ch_o  (blue_ch)
  );

  assign out_data.red   = red_ch;
  assign out_data.green = green_ch;
  assign out_data.blue  = blue_ch;

  // zero saturation must come out grey
  a_grey_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && grey_r[NUM_STAGES-1] |->
      out_data.red == out_data.green && out_data.green == out_data.blue)
    else $error("grey transaction with unequal channels");

  // input held off only with every stage occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&valid_r) && out_stall)
    else $error("input stalled with a bubble in the pipeline");

  // stage 3, when it cannot move, keeps its item
  a_hold_mid: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[3] && !adv[3] |=> valid_r[3])
    else $error("item dropped from a blocked stage");

  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule
